/* design/sle_pkg.sv */
package sle_pkg;

  // Request action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_GET    = 3'd1;
  localparam logic [2:0] ACT_LOCATE = 3'd2;
  localparam logic [2:0] ACT_INSERT = 3'd3;
  localparam logic [2:0] ACT_DELETE = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         found_at;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GET_RD,
    ST_GET_CAP,
    ST_LOC_SCAN,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_DEL_SHIFT,
    ST_RESP
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture request, clear result
    logic clr;        // empty the list
    logic set_ok;
    logic idx_zero;   // pointer setup for locate
    logic idx_count;  // pointer setup for insert
    logic idx_pos;    // pointer setup for delete
    logic rd_get;     // read entry at position
    logic step_ins;   // one shift-up step
    logic step_del;   // one shift-down step
    logic step_loc;   // one scan step
    logic put_ins;    // write new value, count up
    logic fin_del;    // count down
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       get_ok;    // position in 1..count
    logic       ins_ok;    // position in 1..count+1 and room left
    logic       ins_last;  // shift-up reached the target slot
    logic       del_end;   // shift-down reached the tail
    logic       loc_done;  // scan hit or ran out
  } status_t;

endpackage

/* design/sle_ram.sv */
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sle_ctrl.sv */
module sle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  sle_pkg::status_t status,
  output sle_pkg::cmd_t    cmd
);

  sle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::ST_IDLE: begin
        if (req_valid) state_next = sle_pkg::ST_DISPATCH;
      end
      sle_pkg::ST_DISPATCH: begin
        case (status.action)
          sle_pkg::ACT_CLEAR:  state_next = sle_pkg::ST_RESP;
          sle_pkg::ACT_GET:    state_next = status.get_ok ? sle_pkg::ST_GET_RD
                                                          : sle_pkg::ST_RESP;
          sle_pkg::ACT_LOCATE: state_next = sle_pkg::ST_LOC_SCAN;
          sle_pkg::ACT_INSERT: state_next = status.ins_ok ? sle_pkg::ST_INS_SHIFT
                                                          : sle_pkg::ST_RESP;
          sle_pkg::ACT_DELETE: state_next = status.get_ok ? sle_pkg::ST_DEL_SHIFT
                                                          : sle_pkg::ST_RESP;
          default:             state_next = sle_pkg::ST_RESP;
        endcase
      end
      sle_pkg::ST_GET_RD:    state_next = sle_pkg::ST_GET_CAP;
      sle_pkg::ST_GET_CAP:   state_next = sle_pkg::ST_RESP;
      sle_pkg::ST_LOC_SCAN: begin
        if (status.loc_done) state_next = sle_pkg::ST_RESP;
      end
      sle_pkg::ST_INS_SHIFT: begin
        if (status.ins_last) state_next = sle_pkg::ST_INS_PUT;
      end
      sle_pkg::ST_INS_PUT:   state_next = sle_pkg::ST_RESP;
      sle_pkg::ST_DEL_SHIFT: begin
        if (status.del_end) state_next = sle_pkg::ST_RESP;
      end
      sle_pkg::ST_RESP: begin
        if (rsp_ready) state_next = sle_pkg::ST_IDLE;
      end
      default:               state_next = sle_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      sle_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      sle_pkg::ST_DISPATCH: begin
        case (status.action)
          sle_pkg::ACT_CLEAR: cmd.clr = 1'b1;
          sle_pkg::ACT_LOCATE: begin
            cmd.set_ok   = 1'b1;
            cmd.idx_zero = 1'b1;
          end
          sle_pkg::ACT_INSERT: cmd.idx_count = status.ins_ok;
          sle_pkg::ACT_DELETE: cmd.idx_pos   = status.get_ok;
          default: ;
        endcase
      end
      sle_pkg::ST_GET_RD:    cmd.rd_get   = 1'b1;
      sle_pkg::ST_GET_CAP:   cmd.set_ok   = 1'b1;
      sle_pkg::ST_LOC_SCAN:  cmd.step_loc = 1'b1;
      sle_pkg::ST_INS_SHIFT: cmd.step_ins = !status.ins_last;
      sle_pkg::ST_INS_PUT:   cmd.put_ins  = 1'b1;
      sle_pkg::ST_DEL_SHIFT: begin
        cmd.fin_del  = status.del_end;
        cmd.step_del = !status.del_end;
      end
      sle_pkg::ST_RESP:      rsp_valid    = 1'b1;
      default: ;
    endcase
  end

endmodule

/* design/sle_dp.sv */
module sle_dp #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  sle_pkg::req_t    req,
  input  sle_pkg::cmd_t    cmd,
  output sle_pkg::status_t status,
  output sle_pkg::rsp_t    rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = ((CW > 7) ? CW : 7) + 1;

  logic [2:0]         action;
  logic [6:0]         position;
  logic signed [31:0] item_value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               wr_pend;
  logic [AW-1:0]      wr_dst;
  logic               cap_pend;
  logic               cmp_pend;
  logic [AW-1:0]      cmp_idx;
  logic               ok;
  logic signed [31:0] read_value;
  logic [6:0]         found_at;

  logic [W-1:0]  pos_w, pos_m1_w, cnt_w, idx_w, idx_m1_w, cmp_p1_w;
  logic          hit, loc_issue, idx_below, del_head;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  assign pos_w    = W'(position);
  assign pos_m1_w = pos_w - W'(1);
  assign cnt_w    = W'(count);
  assign idx_w    = W'(idx);
  assign idx_m1_w = idx_w - W'(1);
  assign cmp_p1_w = W'(cmp_idx) + W'(1);

  assign idx_below = idx_w < cnt_w;
  assign hit       = cmp_pend && (rdata == item_value);
  assign loc_issue = idx_below && !hit;
  assign del_head  = idx_w == pos_m1_w;

  assign status.action   = action;
  assign status.get_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign status.ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + W'(1))
                           && (cnt_w < W'(DEPTH));
  assign status.ins_last = (idx_w + W'(1)) == pos_w;
  assign status.del_end  = idx_w == cnt_w;
  assign status.loc_done = hit || (!idx_below && !cmp_pend);

  // Memory ports: one read, one write per cycle
  always_comb begin
    if (cmd.rd_get) begin
      raddr = pos_m1_w[AW-1:0];
    end else if (cmd.step_ins) begin
      raddr = idx_m1_w[AW-1:0];
    end else begin
      raddr = idx[AW-1:0];
    end
  end

  assign we    = wr_pend || cmd.put_ins;
  assign waddr = cmd.put_ins ? pos_m1_w[AW-1:0] : wr_dst;
  assign wdata = cmd.put_ins ? item_value : rdata;

  sle_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wr_pend  <= 1'b0;
      cap_pend <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      wr_pend  <= cmd.step_ins || (cmd.step_del && !del_head);
      cap_pend <= cmd.rd_get || (cmd.step_del && del_head);
      cmp_pend <= cmd.step_loc && loc_issue;
      if (cmd.clr) begin
        count <= '0;
      end else if (cmd.put_ins) begin
        count <= count + CW'(1);
      end else if (cmd.fin_del) begin
        count <= count - CW'(1);
      end
    end
  end

  // Request, pointers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action     <= req.action;
      position   <= req.position;
      item_value <= req.item_value;
      ok         <= 1'b0;
      read_value <= '0;
      found_at   <= '0;
    end
    if (cmd.set_ok || cmd.clr || cmd.put_ins || cmd.fin_del) begin
      ok <= 1'b1;
    end
    if (cap_pend) begin
      read_value <= $signed(rdata);
    end
    if (cmd.step_loc && hit) begin
      found_at <= cmp_p1_w[6:0];
    end

    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_count) begin
      idx <= count;
    end else if (cmd.idx_pos) begin
      idx <= pos_m1_w[CW-1:0];
    end else if (cmd.step_ins) begin
      idx <= idx_m1_w[CW-1:0];
    end else if (cmd.step_del || (cmd.step_loc && loc_issue)) begin
      idx <= idx + CW'(1);
    end

    if (cmd.step_ins) begin
      wr_dst <= idx[AW-1:0];
    end else if (cmd.step_del) begin
      wr_dst <= idx_m1_w[AW-1:0];
    end

    if (cmd.step_loc && loc_issue) begin
      cmp_idx <= idx[AW-1:0];
    end
  end

  assign rsp.ok          = ok;
  assign rsp.read_value  = read_value;
  assign rsp.found_at    = found_at;
  assign rsp.entry_count = cnt_w[6:0];

endmodule

/* design/sequential_list_engine.sv */
// Ordered list of up to DEPTH signed 32-bit words, held in one RAM with a
// registered read port and addressed by 1-based position. Each request
// carries one action: clear, get, locate (first match, 0 if absent), insert
// (positions 1..count+1, later entries move up) or delete (entry returned,
// later entries move down). Bad positions, inserts into a full list and
// unknown action codes answer ok=0 and leave the list alone; entry_count
// always shows the count after the request. One request is in flight at a
// time: req_ready is high only while idle, and the next request is taken
// the cycle after the response is taken. Clear and failed requests go from
// dispatch straight to the response; get first reads and captures the entry;
// locate, insert and delete run a scan or shift loop whose length grows with
// the entries it passes. Shifts and scans move one entry per cycle, bounded
// by the single read and single write port of the list RAM; the slowest
// request is a locate that misses on a full list. The list RAM is not
// cleared at reset; only entries below the count are ever read.
module sequential_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sle_pkg::rsp_t rsp
);

  sle_pkg::cmd_t    cmd;
  sle_pkg::status_t status;

  // Sequencer: decodes the action, runs the shift/scan loops
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // List RAM, count, pointers and the response register
  sle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // Never take a new request while a response is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid)
    else $error("request taken while response pending");

  // A response never appears in the cycle after a request is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !rsp_valid)
    else $error("response too early");

  // Back to idle right after the response is taken
  a_resp_to_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) |=> req_ready)
    else $error("not idle after response");

  // At most one RAM operation commanded per cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_get, cmd.step_ins, cmd.step_del, cmd.step_loc, cmd.put_ins}))
    else $error("conflicting RAM commands");

endmodule

/* tb/tb_sequential_list_engine.sv */
`timescale 1ns / 1ps

module tb_sequential_list_engine;

  localparam int LIST_DEPTH = 64;
  // Slowest legal run is well within this timeout, with a wide margin.
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} list_mode_t;

  // Shadow copy of the list; predicts one answer per accepted request and
  // checks the answers in order.
  class list_scoreboard_t;
    logic signed [31:0] slots [LIST_DEPTH];
    int                 fill;
    int                 errors;
    sle_pkg::rsp_t      pending_answers [$];

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_request(sle_pkg::req_t r);
      sle_pkg::rsp_t a;
      int            p;
      int            i;
      a = '0;
      p = int'(r.position);
      case (r.action)
        sle_pkg::ACT_CLEAR: begin
          fill = 0;
          a.ok = 1'b1;
        end
        sle_pkg::ACT_GET: begin
          if (p >= 1 && p <= fill) begin
            a.ok         = 1'b1;
            a.read_value = slots[p-1];
          end
        end
        sle_pkg::ACT_LOCATE: begin
          a.ok = 1'b1;
          for (i = 0; i < fill; i++) begin
            if (slots[i] == r.item_value) begin
              a.found_at = 7'(i + 1);
              break;
            end
          end
        end
        sle_pkg::ACT_INSERT: begin
          if (p >= 1 && p <= fill + 1 && fill < LIST_DEPTH) begin
            for (i = fill; i >= p; i--) slots[i] = slots[i-1];
            slots[p-1] = r.item_value;
            fill++;
            a.ok = 1'b1;
          end
        end
        sle_pkg::ACT_DELETE: begin
          if (p >= 1 && p <= fill) begin
            a.read_value = slots[p-1];
            for (i = p; i < fill; i++) slots[i-1] = slots[i];
            fill--;
            a.ok = 1'b1;
          end
        end
        default: ;  // unknown codes: list untouched, ok stays 0
      endcase
      a.entry_count = 7'(fill);
      pending_answers.push_back(a);
    endfunction

    function void check_response(sle_pkg::rsp_t got);
      sle_pkg::rsp_t want;
      if (pending_answers.size() == 0) begin
        $error({"response with no request outstanding: ",
                "ok=%0d read_value=%0d found_at=%0d entry_count=%0d"},
               got.ok, got.read_value, got.found_at, got.entry_count);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.found_at !== want.found_at) begin
        $error("found_at: expected %0d, got %0d", want.found_at, got.found_at);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  sle_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  sle_pkg::rsp_t rsp;

  list_scoreboard_t sb;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  sequential_list_engine #(.DEPTH(LIST_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: ready is re-rolled every falling edge, so any response can meet
  // a stall.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Response monitor: sampled on the rising edge, where the handshake happens.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[sequential_list_engine] ERROR");
    $finish;
  end

  // Entered and left at a falling edge. Valid stays up on exit, so a
  // back-to-back request keeps it high with no glitch; a gap lowers it once.
  task automatic send_request(sle_pkg::req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Sender holds off until every outstanding answer has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(negedge clk);
  endtask

  // Random traffic in segments: a fill stretch that pushes the list toward
  // full, a mixed stretch, then a drain stretch.
  task automatic run_phase(int idle, int stall, int n_items);
    sle_pkg::req_t r;
    int            roll;
    int            n;
    int            span;
    int            seg;
    list_mode_t    mode;
    int            i;
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (i = 0; i < n_items; i++) begin
      n    = sb.fill;
      seg  = i % 200;
      mode = (seg < 90) ? MODE_FILL : (seg < 140) ? MODE_MIX : MODE_DRAIN;

      // action
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_FILL: begin
          if (roll < 85)      r.action = sle_pkg::ACT_INSERT;
          else if (roll < 90) r.action = sle_pkg::ACT_DELETE;
          else if (roll < 95) r.action = sle_pkg::ACT_GET;
          else                r.action = sle_pkg::ACT_LOCATE;
        end
        MODE_MIX: begin
          if (roll < 2)       r.action = sle_pkg::ACT_CLEAR;
          else if (roll < 4)  r.action = 3'(sle_pkg::ACT_DELETE + $urandom_range(1, 3));
          else if (roll < 40) r.action = sle_pkg::ACT_INSERT;
          else if (roll < 62) r.action = sle_pkg::ACT_DELETE;
          else if (roll < 81) r.action = sle_pkg::ACT_GET;
          else                r.action = sle_pkg::ACT_LOCATE;
        end
        default: begin
          if (roll < 15)      r.action = sle_pkg::ACT_INSERT;
          else if (roll < 70) r.action = sle_pkg::ACT_DELETE;
          else if (roll < 82) r.action = sle_pkg::ACT_GET;
          else if (roll < 99) r.action = sle_pkg::ACT_LOCATE;
          else                r.action = sle_pkg::ACT_CLEAR;
        end
      endcase

      // position: mostly legal, some just off either end, some anywhere
      span = (r.action == sle_pkg::ACT_INSERT) ? n + 1 : n;
      roll = $urandom_range(0, 99);
      if (roll < 85 && span > 0)
        r.position = 7'($urandom_range(1, span));
      else if (roll < 93)
        r.position = $urandom_range(0, 1) ? 7'd0 : 7'(span + 1);
      else
        r.position = 7'($urandom_range(0, 127));

      // value: locate mostly hunts for a live entry; a small pool makes
      // duplicates so first-match ordering gets exercised
      roll = $urandom_range(0, 99);
      if (r.action == sle_pkg::ACT_LOCATE && n > 0 && roll < 50)
        r.item_value = sb.slots[$urandom_range(0, n - 1)];
      else if (roll < 65)
        r.item_value = $urandom_range(0, 4) - 2;
      else if (roll < 72)
        r.item_value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else
        r.item_value = $urandom;

      send_request(r);
    end
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-list misses, append/front/middle inserts, extreme
    // values, duplicate locate, bad positions, unknown codes, clear.
    send_request('{sle_pkg::ACT_GET,    7'd1,   32'sd0});
    send_request('{sle_pkg::ACT_DELETE, 7'd1,   32'sd0});
    send_request('{sle_pkg::ACT_LOCATE, 7'd0,   32'sd0});
    send_request('{sle_pkg::ACT_INSERT, 7'd0,   32'sd5});
    send_request('{sle_pkg::ACT_INSERT, 7'd2,   32'sd5});
    send_request('{sle_pkg::ACT_INSERT, 7'd1,   32'h7fff_ffff});
    send_request('{sle_pkg::ACT_INSERT, 7'd2,   32'h8000_0000});
    send_request('{sle_pkg::ACT_INSERT, 7'd1,   -32'sd1});
    send_request('{sle_pkg::ACT_INSERT, 7'd3,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd1,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd4,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd0,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd5,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd127, 32'sd0});
    send_request('{sle_pkg::ACT_LOCATE, 7'd0,   32'h8000_0000});
    send_request('{sle_pkg::ACT_LOCATE, 7'd0,   32'sd12345});
    send_request('{sle_pkg::ACT_INSERT, 7'd3,   -32'sd1});
    send_request('{sle_pkg::ACT_LOCATE, 7'd0,   -32'sd1});
    send_request('{sle_pkg::ACT_DELETE, 7'd2,   32'sd0});
    send_request('{sle_pkg::ACT_DELETE, 7'd4,   32'sd0});
    send_request('{sle_pkg::ACT_DELETE, 7'd0,   32'sd0});
    send_request('{3'(sle_pkg::ACT_DELETE + 1), 7'd127, 32'haaaa_aaaa});
    send_request('{3'(sle_pkg::ACT_DELETE + 2), 7'd64,  32'h5555_5555});
    send_request('{3'(sle_pkg::ACT_DELETE + 3), 7'd65,  32'sd0});
    send_request('{sle_pkg::ACT_CLEAR,  7'd0,   32'sd0});
    send_request('{sle_pkg::ACT_GET,    7'd1,   32'sd0});

    // Random phases; each starts from a drained pipe.
    wait_drained();
    run_phase(0, 0, 175);
    wait_drained();
    run_phase(46, 0, 175);
    wait_drained();
    run_phase(0, 46, 175);
    wait_drained();
    run_phase(38, 38, 175);

    wait_drained();
    // Quiet tail: long enough for any stray response to show up.
    repeat (LIST_DEPTH + 16) @(negedge clk);

    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("[sequential_list_engine] OK");
    end else begin
      $display("[sequential_list_engine] ERROR");
    end
    $finish;
  end

endmodule
